/* rtl/core/ldl_pkg.sv */
// ---------------------------------------------------------------------------
// ldl_pkg
// Shared types, constants and fixed-point helpers for the LPC solver.
// ---------------------------------------------------------------------------
package ldl_pkg;

  localparam int MaxOrderDef = 32;
  localparam int OrderW      = 6;
  localparam int LagW        = 32;
  localparam int PosW        = 5;
  localparam int ErrW        = 31;
  localparam logic [OrderW-1:0] OrderReset = 6'd16;
  localparam logic [31:0] RegOrder = 32'd0;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_ACC,
    ST_DIV,
    ST_SNAP,
    ST_UPD,
    ST_ERR1,
    ST_ERR2,
    ST_OUT
  } ldl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic init;       // err <= r0, stage = 1
    logic acc_clr;    // j = 0, first step loads acc <= r[i]<<25
    logic acc_step;   // acc += a[j-1]*r[i-j]
    logic div_start;
    logic snap_step;  // snap[j-1] <= a[j-1]
    logic upd_first;  // a[i-1] <= round(k/32), j = 1
    logic upd_step;
    logic err1;       // f
    logic err2;       // err update, stage++
    logic out_clr;    // output index = 0
    logic out_step;
  } ldl_cmd_t;

  // status back to controller
  typedef struct packed {
    logic j_done;     // j reached stage
    logic div_done;
    logic stage_done; // stage reached p
    logic out_done;   // emitting last result
    logic zero;
  } ldl_sts_t;

  // floor((v + 2^(s-1)) / 2^s) on a 128-bit signed value
  function automatic logic signed [127:0] rnd_shift(input logic signed [127:0] v,
                                                    input int unsigned s);
    logic signed [127:0] u;
    u = v + (128'sd1 <<< (s - 1));
    return u >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* rtl/core/ldl_divider.sv */
// ---------------------------------------------------------------------------
// ldl_divider
// Restoring divider for |k| = floor(num/den), num pre-scaled by 32, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module ldl_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,   // already scaled, below den<<31
  input  logic [31:0] den,
  output logic        done,
  output logic [30:0] quot
);
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] rem;
  logic [63:0] sh;
  logic [32:0] trial;

  assign trial = {rem[31:0], sh[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      sh   <= num;
      quot <= '0;
    end else if (run) begin
      sh <= {sh[62:0], 1'b0};
      if (!trial[32]) begin
        rem  <= trial;
        quot <= {quot[29:0], 1'b1};
      end else begin
        rem  <= {rem[31:0], sh[63]};
        quot <= {quot[29:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/core/ldl_datapath.sv */
// ---------------------------------------------------------------------------
// ldl_datapath
// Lag and coefficient memories, MAC, divider and error update.
// ---------------------------------------------------------------------------
module ldl_datapath #(
  parameter int MAX_ORDER = ldl_pkg::MaxOrderDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ldl_pkg::ldl_cmd_t      cmd,
  output ldl_pkg::ldl_sts_t      sts,
  input  logic                   lag_we,
  input  logic [$clog2(MAX_ORDER+1)-1:0] lag_waddr,
  input  logic signed [31:0]     lag_wdata,
  input  logic [6:0]             p,
  output logic [4:0]             coef_position,
  output logic signed [31:0]     pred_coef,
  output logic signed [31:0]     refl_coef,
  output logic [30:0]            pred_error,
  output logic                   zero_energy
);
  import ldl_pkg::*;
  localparam int LAW = $clog2(MAX_ORDER + 1);
  localparam int CAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  logic signed [31:0] lag_mem  [MAX_ORDER+1];
  logic signed [31:0] pred_mem [MAX_ORDER];
  logic signed [31:0] snap_mem [MAX_ORDER];
  logic signed [31:0] refl_mem [MAX_ORDER];

  logic [6:0] stage, j;
  logic signed [63:0] acc;
  logic signed [31:0] err;
  logic signed [31:0] k;
  logic signed [31:0] f;
  logic signed [31:0] r0;
  logic [30:0] quot;
  logic div_done;
  logic [63:0] num_mag;
  logic [31:0] den_mag;
  logic [63:0] num_sc;
  logic        num_big;
  logic signed [127:0] prod, sum, d;

  // ordinary single-port reads, one address each cycle
  logic [LAW-1:0] lag_ra;
  logic [CAW-1:0] pa, sa;
  logic signed [31:0] lag_q, pred_q, snap_q;

  always_comb begin
    lag_ra = LAW'(stage - j);
    pa = CAW'(j - 7'd1);
    sa = CAW'(stage - j - 7'd1);
    if (cmd.out_clr || cmd.out_step) pa = CAW'(j);
  end

  always_ff @(posedge clk) begin
    if (lag_we) lag_mem[lag_waddr] <= lag_wdata;
    lag_q  <= lag_mem[lag_ra];
    pred_q <= pred_mem[pa];
    snap_q <= snap_mem[sa];
  end

  assign num_mag = acc[63] ? 64'(-acc) : 64'(acc);
  assign den_mag = err[31] ? 32'(-err) : 32'(err);
  assign num_big = num_mag >= ({32'd0, den_mag} << 25);
  assign num_sc  = num_mag << 5;

  ldl_divider u_div (
    .clk, .rst,
    .start(cmd.div_start && !num_big && err != 0),
    .num(num_sc), .den(den_mag),
    .done(div_done), .quot(quot)
  );

  // MAC and update terms from the registered read data
  always_comb begin
    prod = 128'(pred_q) * 128'(lag_q);
    sum  = 128'(acc) + prod;
    d    = rnd_shift(128'(k) * 128'(snap_q), 30);
  end

  logic acc_ph, upd_ph;  // read-then-use phase toggles
  logic div_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0; j <= '0; acc_ph <= 1'b0; upd_ph <= 1'b0; div_wait <= 1'b0;
      err <= '0; r0 <= '0;
    end else begin
      // keep a copy of lag zero for the energy check
      if (lag_we && lag_waddr == '0) r0 <= lag_wdata;
      if (cmd.init) begin
        stage <= 7'd1;
        err   <= r0;
      end
      if (cmd.acc_clr) begin
        j      <= 7'd0;
        acc_ph <= 1'b0;
      end
      if (cmd.acc_step) begin
        acc_ph <= !acc_ph;
        if (acc_ph) begin
          if (j == 7'd0) acc <= 64'(lag_q) <<< 25;
          else if (sum > 128'sh7fffffffffffffff) acc <= 64'sh7fffffffffffffff;
          else if (sum < -128'sh8000000000000000) acc <= 64'sh8000000000000000;
          else acc <= sum[63:0];
          j <= j + 7'd1;
        end
      end
      if (cmd.div_start) begin
        div_wait <= 1'b0;
        if (err == 0) k <= '0;
        else if (num_big) begin
          k <= ((acc < 0) == (err < 0)) ? -32'sd1073741824 : 32'sd1073741824;
        end else div_wait <= 1'b1;
        j <= 7'd1;
      end
      if (div_done && div_wait) begin
        div_wait <= 1'b0;
        k <= ((acc < 0) == (err < 0)) ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      end
      if (cmd.snap_step) begin
        acc_ph <= !acc_ph;
        if (acc_ph) begin
          snap_mem[CAW'(j - 7'd1)] <= pred_q;
          j <= j + 7'd1;
        end
      end
      if (cmd.upd_first) begin
        refl_mem[CAW'(stage - 7'd1)] <= k;
        pred_mem[CAW'(stage - 7'd1)] <= 32'(rnd_shift(128'(k), 5));
        j <= 7'd1;
        upd_ph <= 1'b0;
      end
      if (cmd.upd_step) begin
        upd_ph <= !upd_ph;
        if (upd_ph) begin
          pred_mem[CAW'(j - 7'd1)] <= sat32(128'(pred_q) + d);
          j <= j + 7'd1;
        end
      end
      if (cmd.err1)
        f <= 32'(rnd_shift((128'sd1 <<< 60) - 128'(k) * 128'(k), 30));
      if (cmd.err2) begin
        err   <= sat32(rnd_shift(128'(err) * 128'(f), 30));
        stage <= stage + 7'd1;
      end
      if (cmd.out_clr) j <= 7'd0;
      if (cmd.out_step) j <= j + 7'd1;
    end
  end

  logic j_last;
  assign j_last = (j >= stage);
  assign sts.j_done     = j_last;
  assign sts.div_done   = !div_wait && !cmd.div_start;
  assign sts.stage_done = (stage >= p);
  assign sts.out_done   = (j + 7'd1 >= p);
  assign sts.zero       = (r0 == 0);

  // output register, one read per result
  always_ff @(posedge clk) begin
    if (cmd.out_step) begin
      coef_position <= PosW'(j);
      zero_energy   <= (r0 == 0);
      pred_coef     <= (r0 == 0) ? '0 : pred_mem[CAW'(j)];
      refl_coef     <= (r0 == 0) ? '0 : refl_mem[CAW'(j)];
      pred_error    <= (r0 == 0 || err[31]) ? '0 : err[30:0];
    end
  end
endmodule

/* rtl/core/ldl_control.sv */
// ---------------------------------------------------------------------------
// ldl_control
// Sequencer: lag loading, stage loop and result emission.
// ---------------------------------------------------------------------------
module ldl_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ldl_pkg::ldl_sts_t sts,
  output ldl_pkg::ldl_cmd_t cmd,
  output logic              busy,
  output logic              out_valid,
  output logic              out_last
);
  import ldl_pkg::*;
  ldl_state_t state, state_next;
  logic load_done;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_LOAD: if (load_done) begin
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        state_next = ST_OUT;
        if (!sts.zero) state_next = ST_ACC;
        cmd.acc_clr = 1'b1;
        cmd.out_clr = sts.zero;
      end
      ST_ACC: begin
        if (sts.j_done) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else cmd.acc_step = 1'b1;
      end
      ST_DIV: if (sts.div_done) state_next = ST_SNAP;
      ST_SNAP: begin
        if (sts.j_done) begin
          cmd.upd_first = 1'b1;
          state_next = ST_UPD;
        end else cmd.snap_step = 1'b1;
      end
      ST_UPD: begin
        if (sts.j_done) state_next = ST_ERR1;
        else cmd.upd_step = 1'b1;
      end
      ST_ERR1: begin
        cmd.err1 = 1'b1;
        state_next = ST_ERR2;
      end
      ST_ERR2: begin
        cmd.err2 = 1'b1;
        if (sts.stage_done) begin
          cmd.out_clr = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.acc_clr = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_OUT: begin
        cmd.out_step = 1'b1;
        if (sts.out_done) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; out_last <= 1'b0;
    end else begin
      out_valid <= cmd.out_step;
      out_last  <= cmd.out_step && sts.out_done;
    end
  end

  assign busy = (state != ST_LOAD) || load_done;
  assign load_done = (state == ST_LOAD) && start;
endmodule

/* rtl/core/levinson_durbin_lpc_unit.sv */
// ---------------------------------------------------------------------------
// levinson_durbin_lpc_unit
// Fixed-point Levinson-Durbin LPC solver with APB order register.
// ---------------------------------------------------------------------------
// Usage: write order over APB at address 0 (reset 16). Present lags r[0..p]
// one per start pulse while busy is low. From the cycle after the last lag,
// busy stays high: a handoff through the run register and the init state,
// then the recursion. Each stage runs the MAC pass, the serial divider, the
// snapshot pass, the coefficient update and the error update; a stage whose
// k saturates or whose error is exhausted skips the divider, and a zero r0
// skips the recursion altogether. The recursion's length is set by the
// divider and the single-port coefficient memories. Then p results leave
// on consecutive cycles, each marked by result_valid for one cycle, last on
// the final one; the receiver cannot stall them. Busy falls in the cycle
// that presents the last result.
// Reset clears the lag count and control state; memories are not cleared.
// ---------------------------------------------------------------------------
module levinson_durbin_lpc_unit #(
  parameter int MAX_ORDER = ldl_pkg::MaxOrderDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] lag_value,
  output logic               result_valid,
  output logic [4:0]         coef_position,
  output logic signed [31:0] pred_coef,
  output logic signed [31:0] refl_coef,
  output logic [30:0]        pred_error,
  output logic               zero_energy,
  output logic               last
);
  import ldl_pkg::*;
  localparam int LAW = $clog2(MAX_ORDER + 1);

  logic [OrderW-1:0] order;
  logic [6:0] p, cnt;
  ldl_cmd_t cmd;
  ldl_sts_t sts;
  logic ctl_busy, run;

  assign pready = 1'b1;
  assign prdata = {26'd0, order};

  always_ff @(posedge clk) begin
    if (rst) order <= OrderReset;
    else if (psel && penable && pwrite && paddr == 1'b0) order <= pwdata[OrderW-1:0];
  end

  always_comb begin
    p = 7'(order);
    if (p == 7'd0) p = 7'd1;
    if (p > 7'(MAX_ORDER)) p = 7'(MAX_ORDER);
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = ctl_busy || run;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; run <= 1'b0;
    end else begin
      run <= 1'b0;
      if (accept) begin
        if (cnt + 7'd1 >= p + 7'd1) begin
          cnt <= '0; run <= 1'b1;
        end else cnt <= cnt + 7'd1;
      end
    end
  end

  ldl_pkg::ldl_sts_t sts_c;
  ldl_control u_ctl (
    .clk, .rst, .start(run), .sts(sts_c), .cmd,
    .busy(ctl_busy), .out_valid(result_valid), .out_last(last)
  );

  ldl_datapath #(.MAX_ORDER(MAX_ORDER)) u_dp (
    .clk, .rst, .cmd, .sts,
    .lag_we(accept && cnt <= 7'(MAX_ORDER)),
    .lag_waddr(LAW'(cnt)), .lag_wdata(lag_value), .p,
    .coef_position, .pred_coef, .refl_coef, .pred_error, .zero_energy
  );

  assign sts_c = sts;

`ifndef SYNTHESIS
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid) else $error("last without valid");
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result while idle");
  a_no_accept_run: assert property (@(posedge clk) disable iff (rst)
    run |-> busy) else $error("busy low during run");
`endif
endmodule

/* bench/tb_levinson_durbin_lpc_unit.sv */
// ---------------------------------------------------------------------------
// tb_levinson_durbin_lpc_unit
// Self-checking bench for the Levinson-Durbin LPC solver: loads lag frames
// under several orders, predicts every coefficient result in fixed point and
// compares each result transfer, all fields at once, against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_levinson_durbin_lpc_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ldl_pkg::*;

  localparam int MaxOrd    = 32;
  localparam int IdleLimit = 40000;

  typedef struct packed {
    logic [4:0]         pos;
    logic signed [31:0] acoef;
    logic signed [31:0] kcoef;
    logic [30:0]        err;
    logic               zero;
    logic               fin;
  } lpc_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [0:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] lag_value = '0;
  logic               result_valid;
  logic [4:0]         coef_position;
  logic signed [31:0] pred_coef;
  logic signed [31:0] refl_coef;
  logic [30:0]        pred_error;
  logic               zero_energy;
  logic               last;

  // predictor state
  logic signed [31:0] lag_mem [0:MaxOrd];
  int                 lags_loaded = 0;
  logic [5:0]         order_reg = OrderReset;
  lpc_result_t        coef_fifo [$];

  int errors = 0;
  int lags_sent = 0;
  int results_seen = 0;
  int frames_solved = 0;
  int idle_cycles = 0;

  levinson_durbin_lpc_unit DUT (.*);

  always #2 clk = ~clk;

  function automatic logic signed [127:0] round_shr(input logic signed [127:0] v,
                                                    input int s);
    return (v + (128'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic int active_order();
    int p;
    p = order_reg;
    if (p < 1) p = 1;
    if (p > MaxOrd) p = MaxOrd;
    return p;
  endfunction

  // run the recursion over lag_mem[0..p] and queue p results
  task automatic solve_frame(input int p);
    logic signed [31:0]  acoef [0:MaxOrd-1];
    logic signed [31:0]  snap [0:MaxOrd-1];
    logic signed [31:0]  kcoef [0:MaxOrd-1];
    logic signed [31:0]  e;
    logic signed [127:0] acc, prod, num, den, q, k, f;
    logic                zero;
    lpc_result_t         res;
    zero = (lag_mem[0] == 0);
    e = zero ? 32'sd0 : lag_mem[0];
    if (!zero) begin
      for (int i = 1; i <= p; i++) begin
        acc = lag_mem[i];
        acc = acc <<< 25;
        for (int j = 1; j < i; j++) begin
          prod = acoef[j-1];
          prod = prod * lag_mem[i-j];
          acc = acc + prod;
          if (acc > 128'sh7fffffffffffffff) acc = 128'sh7fffffffffffffff;
          if (acc < -128'sh8000000000000000) acc = -128'sh8000000000000000;
        end
        if (e == 0) begin
          k = 0;
        end else begin
          num = (acc < 0) ? -acc : acc;
          den = e;
          if (den < 0) den = -den;
          if (num >= (den <<< 25)) q = 128'sd1 <<< 30;
          else q = (num <<< 5) / den;
          if (q > (128'sd1 <<< 30)) q = 128'sd1 <<< 30;
          k = ((acc < 0) == (e < 0)) ? -q : q;
        end
        kcoef[i-1] = k[31:0];
        for (int j = 1; j < i; j++) snap[j-1] = acoef[j-1];
        acoef[i-1] = round_shr(k, 5);
        for (int j = 1; j < i; j++) begin
          prod = snap[i-j-1];
          acoef[j-1] = clip32(acoef[j-1] + round_shr(k * prod, 30));
        end
        f = round_shr((128'sd1 <<< 60) - k * k, 30);
        prod = e;
        e = clip32(round_shr(prod * f, 30));
      end
    end
    for (int i = 0; i < p; i++) begin
      res.pos   = i[4:0];
      res.acoef = zero ? '0 : acoef[i];
      res.kcoef = zero ? '0 : kcoef[i];
      res.err   = (zero || e <= 0) ? '0 : e[30:0];
      res.zero  = zero;
      res.fin   = (i == p - 1);
      coef_fifo.push_back(res);
    end
    frames_solved++;
  endtask

  task automatic predict_lag(input logic signed [31:0] v);
    int p;
    p = active_order();
    if (lags_loaded <= MaxOrd) lag_mem[lags_loaded] = v;
    lags_loaded++;
    if (lags_loaded >= p + 1) begin
      lags_loaded = 0;
      solve_frame(p);
    end
  endtask

  task automatic pause_lag();
    int r, gap;
    r = $urandom_range(0, 99);
    if (r < 45) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(15, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_lag(input logic signed [31:0] v, input bit idle_between);
    start     <= 1'b1;
    lag_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_lag(v);
    lags_sent++;
    if (idle_between) pause_lag();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (coef_fifo.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_order(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegOrder[0:0];
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    order_reg = value[5:0];
    // read back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[5:0] !== value[5:0]) begin
      $display("%0t order readback: expected %0d actual %0d", $realtime, value[5:0],
               prdata[5:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame(input logic signed [31:0] lags [], input bit gaps);
    foreach (lags[n]) send_lag(lags[n], gaps);
  endtask

  // corner frames: saturated k, zero energy, negative energy, exhausted error
  task automatic test_corner_frames();
    write_order(32'd1);
    send_frame('{32'sh7fffffff, 32'sh80000000}, 1'b1);
    send_frame('{32'sh80000000, 32'sh7fffffff}, 1'b1);
    send_frame('{-32'sd5000, 32'sd1234}, 1'b1);
    wait_drained();
    write_order(32'd0);
    send_frame('{32'sd1, -32'sd1}, 1'b1);
    wait_drained();
    write_order(32'd2);
    send_frame('{32'sd0, 32'sd77, -32'sd99}, 1'b1);
    send_frame('{32'sd1000, -32'sd1000, 32'sd500}, 1'b0);
    wait_drained();
  endtask

  // shrink the order while a frame is partly loaded
  task automatic test_order_change_mid_load();
    write_order(32'd16);
    send_frame('{32'sd900000, 32'sd450000, -32'sd200000, 32'sd10, 32'sd5}, 1'b1);
    wait_drained();
    write_order(32'd2);
    send_lag(32'sd3, 1'b0);
    wait_drained();
  endtask

  function automatic logic signed [31:0] next_lag(input logic signed [31:0] prev);
    longint t;
    t = prev;
    t = t * (longint'($urandom_range(0, 2048)) - 1024) / 1024;
    return t[31:0];
  endfunction

  task automatic test_random_frames(input int budget);
    int p, frame_no;
    bit noisy, gaps;
    logic [31:0] ord;
    logic signed [31:0] v;
    frame_no = 0;
    while (budget > 0) begin
      if (frame_no == 2) ord = 32'd63;
      else if (frame_no == 5) ord = 32'd32;
      else if ($urandom_range(0, 9) == 0) ord = $urandom_range(9, 20);
      else ord = $urandom_range(1, 8);
      if (ord[5:0] != order_reg) begin
        wait_drained();
        write_order(ord);
      end
      p = active_order();
      noisy = ($urandom_range(0, 99) < 15);
      gaps = ($urandom_range(0, 3) != 0);
      v = noisy ? $urandom : $urandom_range(1, 32'h7fffffff) >> $urandom_range(0, 20);
      for (int n = 0; n <= p; n++) begin
        send_lag(v, gaps);
        v = noisy ? $urandom : next_lag(v);
        budget--;
      end
      frame_no++;
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    lpc_result_t want;
    if (result_valid === 1'b1) begin
      results_seen++;
      if (coef_fifo.size() == 0) begin
        $display("%0t unexpected result: position %0d", $realtime, coef_position);
        errors++;
      end else begin
        want = coef_fifo.pop_front();
        if (want !== {coef_position, pred_coef, refl_coef, pred_error, zero_energy, last}) begin
          $display("%0t result mismatch: expected pos %0d a %0d k %0d err %0d zero %0b last %0b",
                   $realtime, want.pos, want.acoef, want.kcoef, want.err, want.zero,
                   want.fin);
          $display("%0t                  actual   pos %0d a %0d k %0d err %0d zero %0b last %0b",
                   $realtime, coef_position, pred_coef, refl_coef, pred_error,
                   zero_energy, last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || result_valid === 1'b1 || (psel && penable) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_frames();
    test_order_change_mid_load();
    test_random_frames(110);
    repeat (50) @(posedge clk);
    if (coef_fifo.size() != 0) begin
      $display("%0t %0d expected results never arrived", $realtime, coef_fifo.size());
      errors++;
    end
    $display("Covered %0d lags in %0d frames, %0d coefficient results checked.",
             lags_sent, frames_solved, results_seen);
    $display("Orders 0..63 incl. clamped ones, zero/negative energy, mid-load order change.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
